// ----- sv/gnep_pkg.sv -----
package gnep_pkg;

  localparam int NUM_VERTICES_DEF     = 32;
  localparam int EDGES_PER_VERTEX_DEF = 8;
  localparam int WEIGHT_BITS_DEF      = 16;

  localparam int KIND_W      = 2;
  localparam int VERTEX_W    = 5;
  localparam int IN_WEIGHT_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_OUT     = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

endpackage

// ----- sv/gnep_if.sv -----
interface gnep_in_if import gnep_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [VERTEX_W-1:0]    edge_source;
  logic [VERTEX_W-1:0]    edge_dest;
  logic [IN_WEIGHT_W-1:0] edge_weight;

  modport source (output valid, kind, edge_source, edge_dest, edge_weight, input ready);
  modport sink (input valid, kind, edge_source, edge_dest, edge_weight, output ready);
endinterface

interface gnep_out_if import gnep_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] path_vertex;
  logic                found;
  logic                last;

  modport source (output valid, path_vertex, found, last, input ready);
  modport sink (input valid, path_vertex, found, last, output ready);
endinterface

interface gnep_cfg_if import gnep_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VERTEX_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/greedy_nearest_edge_path_search_core.sv -----
// Edge load: a count read after acceptance, then the edge and count write; clear acts on acceptance.
// Search: an init state, then per step a visit of a vertex, a count read, a scan of its listed edges
// (one edge memory read a cycle), a decide and a pop on a backtrack; then one path word per cycle
// unless stalled. One item is in work at a time; the count memory read-modify-write sets the load rate.
// Reset clears the control state and the list valid bits at once; start is 0, target is 1.
module greedy_nearest_edge_path_search_core import gnep_pkg::*; #(
  parameter int NUM_VERTICES     = NUM_VERTICES_DEF,
  parameter int EDGES_PER_VERTEX = EDGES_PER_VERTEX_DEF,
  parameter int WEIGHT_BITS      = WEIGHT_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  gnep_cfg_if.sink  cfg_i,
  gnep_in_if.sink   in_i,
  gnep_out_if.source out_o
);

  localparam int VIW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int DW  = $clog2(NUM_VERTICES + 1);
  localparam int CW  = $clog2(EDGES_PER_VERTEX + 1);
  localparam int IW  = (EDGES_PER_VERTEX > 1) ? $clog2(EDGES_PER_VERTEX) : 1;
  localparam int NE  = NUM_VERTICES * EDGES_PER_VERTEX;
  localparam int AW  = (NE > 1) ? $clog2(NE) : 1;
  localparam int SW  = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int EW  = VIW + SW;

  localparam logic [DW-1:0] NvD  = DW'(NUM_VERTICES);
  localparam logic [CW-1:0] EpvC = CW'(EDGES_PER_VERTEX);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LD_RD  = 4'd1;
  localparam logic [3:0] S_LD_WR  = 4'd2;
  localparam logic [3:0] S_INIT   = 4'd3;
  localparam logic [3:0] S_VISIT  = 4'd4;
  localparam logic [3:0] S_CNT    = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_POP    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_NF     = 4'd10;

  logic [3:0]              state_q, state_d;
  logic [NUM_VERTICES-1:0] cvalid_q, cvalid_d;
  logic [NUM_VERTICES-1:0] visited_q, visited_d;
  logic [DW-1:0]           depth_q, depth_d;
  logic [VERTEX_W-1:0]     start_q, target_q;
  logic                    ov_q, ov_d;

  logic [VIW-1:0]          src_q, src_d, dst_q, dst_d, cur_q, cur_d, best_q, best_d;
  logic [SW-1:0]           wgt_q, wgt_d, bw_q, bw_d;
  logic [AW-1:0]           base_q, base_d;
  logic [CW-1:0]           n_q, n_d;
  logic [IW-1:0]           i_q, i_d;
  logic                    have_q, have_d;
  logic [DW-1:0]           j_q, j_d;
  logic [VERTEX_W-1:0]     opv_q, opv_d;
  logic                    ofound_q, ofound_d, olast_q, olast_d;

  logic            cnt_we, cnt_re;
  logic [VIW-1:0]  cnt_waddr, cnt_raddr;
  logic [CW-1:0]   cnt_wdata, cnt_rdata;
  logic            edge_we, edge_re;
  logic [AW-1:0]   edge_waddr, edge_raddr;
  logic [EW-1:0]   edge_wdata, edge_rdata;
  logic            stk_we, stk_re;
  logic [VIW-1:0]  stk_waddr, stk_raddr;
  logic [VIW-1:0]  stk_wdata, stk_rdata;

  logic            in_acc, out_free;
  logic            edge_ok, search_ok, take;
  logic [CW-1:0]   cnt_eff, i_nxt;
  logic [DW-1:0]   j_nxt;
  logic            lst;
  logic [VIW-1:0]  ed;
  logic [SW-1:0]   ew;

  gnep_ram #(.WIDTH(CW), .DEPTH(NUM_VERTICES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  gnep_ram #(.WIDTH(EW), .DEPTH(NE)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  gnep_ram #(.WIDTH(VIW), .DEPTH(NUM_VERTICES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign in_i.ready        = (state_q == S_IDLE);
  assign in_acc            = in_i.valid && in_i.ready;
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = ov_q;
  assign out_o.path_vertex = opv_q;
  assign out_o.found       = ofound_q;
  assign out_o.last        = olast_q;
  assign out_free          = !ov_q || out_o.ready;

  assign edge_ok   = (int'(in_i.edge_source) < NUM_VERTICES) &&
                     (int'(in_i.edge_dest) < NUM_VERTICES);
  assign search_ok = (int'(start_q) < NUM_VERTICES) && (int'(target_q) < NUM_VERTICES);

  assign ed      = edge_rdata[EW-1:SW];
  assign ew      = edge_rdata[SW-1:0];
  assign take    = !visited_q[ed] && (!have_q || (ew < bw_q));
  assign i_nxt   = CW'(i_q) + 1'b1;
  assign j_nxt   = j_q + 1'b1;
  assign lst     = (j_nxt == depth_q) || (int'(j_nxt) == MAX_OUT);

  always_comb begin
    state_d   = state_q;
    cvalid_d  = cvalid_q;
    visited_d = visited_q;
    depth_d   = depth_q;
    ov_d      = ov_q && !out_o.ready;
    src_d     = src_q;
    dst_d     = dst_q;
    wgt_d     = wgt_q;
    cur_d     = cur_q;
    best_d    = best_q;
    bw_d      = bw_q;
    base_d    = base_q;
    n_d       = n_q;
    i_d       = i_q;
    have_d    = have_q;
    j_d       = j_q;
    opv_d     = opv_q;
    ofound_d  = ofound_q;
    olast_d   = olast_q;

    cnt_we     = 1'b0;
    cnt_re     = 1'b0;
    cnt_waddr  = src_q;
    cnt_raddr  = cur_q;
    cnt_wdata  = '0;
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_waddr = '0;
    edge_raddr = base_q;
    edge_wdata = {dst_q, wgt_q};
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_waddr  = VIW'(depth_q);
    stk_raddr  = '0;
    stk_wdata  = best_q;
    cnt_eff    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          src_d = VIW'(in_i.edge_source);
          dst_d = VIW'(in_i.edge_dest);
          wgt_d = SW'(in_i.edge_weight);
          unique case (in_i.kind)
            KIND_LOAD: begin
              if (edge_ok) begin
                state_d = S_LD_RD;
              end
            end
            KIND_SEARCH: state_d = S_INIT;
            KIND_CLEAR:  cvalid_d = '0;
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = src_q;
        state_d   = S_LD_WR;
      end
      S_LD_WR: begin
        cnt_eff = cvalid_q[src_q] ? cnt_rdata : '0;
        if (cnt_eff < EpvC) begin
          edge_we          = 1'b1;
          edge_waddr       = AW'(int'(src_q) * EDGES_PER_VERTEX + int'(cnt_eff));
          cnt_we           = 1'b1;
          cnt_waddr        = src_q;
          cnt_wdata        = cnt_eff + 1'b1;
          cvalid_d[src_q]  = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_INIT: begin
        visited_d = '0;
        if (search_ok) begin
          stk_we                     = 1'b1;
          stk_waddr                  = '0;
          stk_wdata                  = VIW'(start_q);
          visited_d[VIW'(start_q)]   = 1'b1;
          depth_d                    = DW'(1);
          cur_d                      = VIW'(start_q);
          state_d                    = S_VISIT;
        end else begin
          depth_d = '0;
          state_d = S_NF;
        end
      end
      S_VISIT: begin
        if (cur_q == VIW'(target_q)) begin
          j_d       = '0;
          stk_re    = 1'b1;
          stk_raddr = '0;
          state_d   = S_EMIT;
        end else begin
          cnt_re    = 1'b1;
          cnt_raddr = cur_q;
          base_d    = AW'(int'(cur_q) * EDGES_PER_VERTEX);
          state_d   = S_CNT;
        end
      end
      S_CNT: begin
        cnt_eff = cvalid_q[cur_q] ? cnt_rdata : '0;
        n_d     = cnt_eff;
        i_d     = '0;
        have_d  = 1'b0;
        if (cnt_eff == '0) begin
          state_d = S_DECIDE;
        end else begin
          edge_re    = 1'b1;
          edge_raddr = base_q;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (take) begin
          have_d = 1'b1;
          best_d = ed;
          bw_d   = ew;
        end
        if (i_nxt < n_q) begin
          i_d        = IW'(i_nxt);
          edge_re    = 1'b1;
          edge_raddr = base_q + AW'(i_nxt);
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (have_q && (depth_q < NvD)) begin
          stk_we            = 1'b1;
          stk_waddr         = VIW'(depth_q);
          stk_wdata         = best_q;
          visited_d[best_q] = 1'b1;
          depth_d           = depth_q + 1'b1;
          cur_d             = best_q;
          state_d           = S_VISIT;
        end else begin
          depth_d = depth_q - 1'b1;
          if (depth_q == DW'(1)) begin
            state_d = S_NF;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = VIW'(depth_q - DW'(2));
            state_d   = S_POP;
          end
        end
      end
      S_POP: begin
        cur_d   = stk_rdata;
        state_d = S_VISIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          opv_d    = VERTEX_W'(stk_rdata);
          ofound_d = 1'b1;
          olast_d  = lst;
          if (lst) begin
            state_d = S_IDLE;
          end else begin
            j_d       = j_nxt;
            stk_re    = 1'b1;
            stk_raddr = VIW'(j_nxt);
          end
        end
      end
      S_NF: begin
        if (out_free) begin
          ov_d     = 1'b1;
          opv_d    = '0;
          ofound_d = 1'b0;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cvalid_q  <= '0;
      visited_q <= '0;
      depth_q   <= '0;
      ov_q      <= 1'b0;
      start_q   <= '0;
      target_q  <= VERTEX_W'(1);
    end else begin
      state_q   <= state_d;
      cvalid_q  <= cvalid_d;
      visited_q <= visited_d;
      depth_q   <= depth_d;
      ov_q      <= ov_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CFG_START:  start_q <= cfg_i.data;
          CFG_TARGET: target_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    wgt_q    <= wgt_d;
    cur_q    <= cur_d;
    best_q   <= best_d;
    bw_q     <= bw_d;
    base_q   <= base_d;
    n_q      <= n_d;
    i_q      <= i_d;
    have_q   <= have_d;
    j_q      <= j_d;
    opv_q    <= opv_d;
    ofound_q <= ofound_d;
    olast_q  <= olast_d;
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= NvD)
    else $error("path stack depth exceeds the vertex count");

  a_visit_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VISIT) |-> visited_q[cur_q])
    else $error("current vertex is not marked visited");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_VISIT) || (state_q == S_CNT) || (state_q == S_SCAN) ||
     (state_q == S_DECIDE)) |-> (depth_q != '0))
    else $error("search step with an empty path stack");

  a_not_found_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ofound_q) |-> (olast_q && (opv_q == '0)))
    else $error("not-found word is malformed");
`endif

endmodule

// ----- sv/gnep_ram.sv -----
module gnep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
